### rtl/hsvrgb_pkg.sv
`timescale 1ns / 1ps
// Package for the HSV to RGB converter: widths, constants, codes and stage word types.
// Depends on nothing; every module of the converter refers to it by scoped names.
package hsvrgb_pkg;

    // Fraction bits of the hue position inside a sector.
    localparam int FRAC_BITS = 8;

    // Field widths of the input and result words.
    localparam int HUE_W = 15;
    localparam int Q8_W = 9;
    localparam int Q8_FRAC = 8;
    localparam int CH_W = 8;
    localparam int RGB_W = 3 * CH_W;

    // Range limits and sector geometry (hue in 1/64 degree).
    localparam int Q8_ONE = 256;
    localparam int SECTOR_UNITS = 3840;
    localparam int SECTOR_COUNT = 6;
    localparam int HUE_MAX = SECTOR_UNITS * SECTOR_COUNT;
    localparam int SECTOR_W = 3;
    localparam int REM_W = 12;

    // Value scaled by 255, kept exact.
    localparam int V255_W = Q8_W + Q8_FRAC;

    // Exact division by the sector width: multiply by a rounded-up reciprocal.
    // With a numerator below 2^NUM_W and 2^REM_W >= SECTOR_UNITS the quotient is exact.
    localparam int NUM_W = REM_W + FRAC_BITS;
    localparam int DIV_SHIFT = NUM_W + REM_W;
    localparam int MULT_W = DIV_SHIFT - REM_W + 1;
    localparam int DIVP_W = NUM_W + MULT_W;
    localparam logic [63:0] DIV_MULT_FULL =
        ((64'd1 << DIV_SHIFT) + 64'(SECTOR_UNITS - 1)) / 64'(SECTOR_UNITS);
    localparam logic [MULT_W-1:0] DIV_MULT = DIV_MULT_FULL[MULT_W-1:0];

    // Weights for q and t carry FRAC_BITS more fraction bits than saturation.
    localparam int WGT_W = Q8_W + FRAC_BITS;
    localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(Q8_ONE) << FRAC_BITS;
    localparam int P_PROD_W = V255_W + Q8_W;
    localparam int QT_PROD_W = V255_W + WGT_W;
    localparam int P_SHIFT = 2 * Q8_FRAC;
    localparam int QT_SHIFT = P_SHIFT + FRAC_BITS;

    // Hue sectors, named after the color at their start.
    typedef enum logic [SECTOR_W-1:0] {
        SEC_RED     = 3'd0,
        SEC_YELLOW  = 3'd1,
        SEC_GREEN   = 3'd2,
        SEC_CYAN    = 3'd3,
        SEC_BLUE    = 3'd4,
        SEC_MAGENTA = 3'd5
    } sector_t;

    // How the final word is formed.
    typedef enum logic [1:0] {
        KIND_COLOR   = 2'd0,
        KIND_GREY    = 2'd1,
        KIND_INVALID = 2'd2
    } kind_t;

    // Input and result words.
    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [Q8_W-1:0]  saturation;
        logic [Q8_W-1:0]  brightness;
    } hsv_t;

    typedef struct packed {
        logic [RGB_W-1:0] rgb_word;
        logic             invalid;
    } rgb_t;

    // Pipeline stage words.
    typedef struct packed {
        kind_t             kind;
        sector_t           sector;
        logic [REM_W-1:0]  rem;
        logic [Q8_W-1:0]   sat;
        logic [V255_W-1:0] v255;
    } split_t;

    typedef struct packed {
        kind_t                kind;
        sector_t              sector;
        logic [FRAC_BITS-1:0] frac;
        logic [Q8_W-1:0]      sat;
        logic [V255_W-1:0]    v255;
    } frac_t;

    typedef struct packed {
        kind_t             kind;
        sector_t           sector;
        logic [WGT_W-1:0]  sf;
        logic [Q8_W-1:0]   sat;
        logic [V255_W-1:0] v255;
    } sfrac_t;

    typedef struct packed {
        kind_t           kind;
        sector_t         sector;
        logic [CH_W-1:0] vi;
        logic [CH_W-1:0] pi;
        logic [CH_W-1:0] qi;
        logic [CH_W-1:0] ti;
    } chan_t;

    // Hue at the start of a sector.
    function automatic logic [HUE_W-1:0] sector_base(input logic [SECTOR_W-1:0] idx);
        return HUE_W'(int'(idx) * SECTOR_UNITS);
    endfunction

endpackage

### rtl/hsvrgb_split.sv
`timescale 1ns / 1ps
// First two pipeline stages: range check, sector split and fraction inside the sector.
// Depends on hsvrgb_pkg.
module hsvrgb_split (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  hsvrgb_pkg::hsv_t  up_word,
    output logic              dn_valid,
    input  logic              dn_ready,
    output hsvrgb_pkg::frac_t dn_word
);

    hsvrgb_pkg::split_t s1_reg;
    hsvrgb_pkg::split_t s1_next;
    logic               s1_valid_reg;
    hsvrgb_pkg::frac_t  s2_reg;
    hsvrgb_pkg::frac_t  s2_next;
    logic               s2_valid_reg;
    logic               s1_ready;
    logic               s2_ready;
    logic [hsvrgb_pkg::SECTOR_W-1:0] raw_sector;
    logic [hsvrgb_pkg::DIVP_W-1:0]   div_prod;

    // A stage takes a new word when it is empty or its word moves on.
    assign s2_ready = !s2_valid_reg || dn_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign up_ready = s1_ready;

    // Stage 1: classify, find the sector by parallel compares, and scale value by 255.
    always_comb
    begin
        raw_sector = '0;
        for (int k = 1; k <= hsvrgb_pkg::SECTOR_COUNT; k++)
        begin
            if (up_word.hue >= hsvrgb_pkg::sector_base(hsvrgb_pkg::SECTOR_W'(k)))
            begin
                raw_sector = hsvrgb_pkg::SECTOR_W'(k);
            end
        end
        s1_next.rem = hsvrgb_pkg::REM_W'(up_word.hue - hsvrgb_pkg::sector_base(raw_sector));
        // A hue of exactly 360 degrees folds back onto the red sector.
        if (raw_sector == hsvrgb_pkg::SECTOR_W'(hsvrgb_pkg::SECTOR_COUNT))
        begin
            s1_next.sector = hsvrgb_pkg::SEC_RED;
        end
        else
        begin
            s1_next.sector = hsvrgb_pkg::sector_t'(raw_sector);
        end
        if (up_word.hue > hsvrgb_pkg::HUE_W'(hsvrgb_pkg::HUE_MAX)
            || up_word.saturation > hsvrgb_pkg::Q8_W'(hsvrgb_pkg::Q8_ONE)
            || up_word.brightness > hsvrgb_pkg::Q8_W'(hsvrgb_pkg::Q8_ONE))
        begin
            s1_next.kind = hsvrgb_pkg::KIND_INVALID;
        end
        else if (up_word.saturation == '0)
        begin
            s1_next.kind = hsvrgb_pkg::KIND_GREY;
        end
        else
        begin
            s1_next.kind = hsvrgb_pkg::KIND_COLOR;
        end
        s1_next.sat = up_word.saturation;
        s1_next.v255 = (hsvrgb_pkg::V255_W'(up_word.brightness) << hsvrgb_pkg::Q8_FRAC)
                       - hsvrgb_pkg::V255_W'(up_word.brightness);
    end

    // Stage 2: fraction = (rem << FRAC_BITS) / sector width through the reciprocal.
    assign div_prod = hsvrgb_pkg::DIVP_W'({s1_reg.rem, {hsvrgb_pkg::FRAC_BITS{1'b0}}})
                      * hsvrgb_pkg::DIVP_W'(hsvrgb_pkg::DIV_MULT);

    always_comb
    begin
        s2_next.kind = s1_reg.kind;
        s2_next.sector = s1_reg.sector;
        s2_next.frac = div_prod[hsvrgb_pkg::DIV_SHIFT +: hsvrgb_pkg::FRAC_BITS];
        s2_next.sat = s1_reg.sat;
        s2_next.v255 = s1_reg.v255;
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= up_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Stage words.
    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_reg <= s1_next;
        end
        if (s2_ready)
        begin
            s2_reg <= s2_next;
        end
    end

    assign dn_valid = s2_valid_reg;
    assign dn_word = s2_reg;

endmodule

### rtl/hsvrgb_weight.sv
`timescale 1ns / 1ps
// Stages three and four: saturation times fraction, then the p, q and t channel products.
// Depends on hsvrgb_pkg.
module hsvrgb_weight (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  hsvrgb_pkg::frac_t up_word,
    output logic              dn_valid,
    input  logic              dn_ready,
    output hsvrgb_pkg::chan_t dn_word
);

    hsvrgb_pkg::sfrac_t s3_reg;
    hsvrgb_pkg::sfrac_t s3_next;
    logic               s3_valid_reg;
    hsvrgb_pkg::chan_t  s4_reg;
    hsvrgb_pkg::chan_t  s4_next;
    logic               s4_valid_reg;
    logic               s3_ready;
    logic               s4_ready;
    logic [hsvrgb_pkg::Q8_W-1:0]      wp;
    logic [hsvrgb_pkg::WGT_W-1:0]     wq;
    logic [hsvrgb_pkg::WGT_W-1:0]     wt;
    logic [hsvrgb_pkg::P_PROD_W-1:0]  prod_p;
    logic [hsvrgb_pkg::QT_PROD_W-1:0] prod_q;
    logic [hsvrgb_pkg::QT_PROD_W-1:0] prod_t;

    assign s4_ready = !s4_valid_reg || dn_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign up_ready = s3_ready;

    // Stage 3: s * f.
    always_comb
    begin
        s3_next.kind = up_word.kind;
        s3_next.sector = up_word.sector;
        s3_next.sf = hsvrgb_pkg::WGT_W'(up_word.sat) * hsvrgb_pkg::WGT_W'(up_word.frac);
        s3_next.sat = up_word.sat;
        s3_next.v255 = up_word.v255;
    end

    // Stage 4: weights 1-s, 1-s*f and 1-s*(1-f), each times 255*v, then truncated.
    assign wp = hsvrgb_pkg::Q8_W'(hsvrgb_pkg::Q8_ONE) - s3_reg.sat;
    assign wq = hsvrgb_pkg::WGT_ONE - s3_reg.sf;
    assign wt = hsvrgb_pkg::WGT_W'((hsvrgb_pkg::WGT_W + 1)'(hsvrgb_pkg::WGT_ONE)
                + (hsvrgb_pkg::WGT_W + 1)'(s3_reg.sf)
                - ((hsvrgb_pkg::WGT_W + 1)'(s3_reg.sat) << hsvrgb_pkg::FRAC_BITS));
    assign prod_p = hsvrgb_pkg::P_PROD_W'(s3_reg.v255) * hsvrgb_pkg::P_PROD_W'(wp);
    assign prod_q = hsvrgb_pkg::QT_PROD_W'(s3_reg.v255) * hsvrgb_pkg::QT_PROD_W'(wq);
    assign prod_t = hsvrgb_pkg::QT_PROD_W'(s3_reg.v255) * hsvrgb_pkg::QT_PROD_W'(wt);

    always_comb
    begin
        s4_next.kind = s3_reg.kind;
        s4_next.sector = s3_reg.sector;
        s4_next.vi = s3_reg.v255[hsvrgb_pkg::Q8_FRAC +: hsvrgb_pkg::CH_W];
        s4_next.pi = prod_p[hsvrgb_pkg::P_SHIFT +: hsvrgb_pkg::CH_W];
        s4_next.qi = prod_q[hsvrgb_pkg::QT_SHIFT +: hsvrgb_pkg::CH_W];
        s4_next.ti = prod_t[hsvrgb_pkg::QT_SHIFT +: hsvrgb_pkg::CH_W];
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s3_ready)
            begin
                s3_valid_reg <= up_valid;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Stage words.
    always_ff @(posedge clk)
    begin
        if (s3_ready)
        begin
            s3_reg <= s3_next;
        end
        if (s4_ready)
        begin
            s4_reg <= s4_next;
        end
    end

    assign dn_valid = s4_valid_reg;
    assign dn_word = s4_reg;

endmodule

### rtl/hsvrgb_mix.sv
`timescale 1ns / 1ps
// Final stage: orders the channels by sector, applies grey and invalid words, output register.
// Depends on hsvrgb_pkg.
module hsvrgb_mix (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  hsvrgb_pkg::chan_t up_word,
    output logic              out_valid,
    input  logic              out_stall,
    output hsvrgb_pkg::rgb_t  out_word
);

    hsvrgb_pkg::rgb_t rgb_reg;
    hsvrgb_pkg::rgb_t rgb_next;
    logic             valid_reg;
    logic             ready;
    logic [hsvrgb_pkg::CH_W-1:0] red;
    logic [hsvrgb_pkg::CH_W-1:0] green;
    logic [hsvrgb_pkg::CH_W-1:0] blue;

    // The register loads when empty or when its word is being taken.
    assign ready = !valid_reg || !out_stall;
    assign up_ready = ready;

    // Channel order per sector.
    always_comb
    begin
        case (up_word.sector)
            hsvrgb_pkg::SEC_YELLOW:
            begin
                red = up_word.qi;
                green = up_word.vi;
                blue = up_word.pi;
            end
            hsvrgb_pkg::SEC_GREEN:
            begin
                red = up_word.pi;
                green = up_word.vi;
                blue = up_word.ti;
            end
            hsvrgb_pkg::SEC_CYAN:
            begin
                red = up_word.pi;
                green = up_word.qi;
                blue = up_word.vi;
            end
            hsvrgb_pkg::SEC_BLUE:
            begin
                red = up_word.ti;
                green = up_word.pi;
                blue = up_word.vi;
            end
            hsvrgb_pkg::SEC_MAGENTA:
            begin
                red = up_word.vi;
                green = up_word.pi;
                blue = up_word.qi;
            end
            default:
            begin
                red = up_word.vi;
                green = up_word.ti;
                blue = up_word.pi;
            end
        endcase
    end

    // Out-of-range inputs give all ones; zero saturation gives grey.
    always_comb
    begin
        case (up_word.kind)
            hsvrgb_pkg::KIND_INVALID:
            begin
                rgb_next.rgb_word = '1;
                rgb_next.invalid = 1'b1;
            end
            hsvrgb_pkg::KIND_GREY:
            begin
                rgb_next.rgb_word = {up_word.vi, up_word.vi, up_word.vi};
                rgb_next.invalid = 1'b0;
            end
            default:
            begin
                rgb_next.rgb_word = {red, green, blue};
                rgb_next.invalid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready)
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word = rgb_reg;

endmodule

### rtl/hsv_to_rgb_converter.sv
`timescale 1ns / 1ps
// Top level of the HSV to RGB converter: five-stage pipeline and its handshake.
// Depends on hsvrgb_pkg, hsvrgb_split, hsvrgb_weight and hsvrgb_mix.
//
// Usage:
// The hsv channel carries one word per pixel: hue in 1/64 degree (0..23040), saturation
// and brightness in Q8 (0..256). The rgb channel returns one word per input word, in
// order: a packed 0xRRGGBB color and an invalid flag. Inputs out of range give all ones
// with invalid set; zero saturation gives grey.
// A word is taken at a rising edge where valid is high and stall is low.
// The five register stages are sector split, fraction multiply, s*f multiply, channel
// multiplies and output; rgb_valid rises when the word reaches the output register.
// Throughput is one word per cycle unless rgb_stall holds the pipeline; stages two and
// three hold one multiplier each, stage four the three channel multipliers side by side.
// When rgb_stall is high, the output word holds and the stages behind it keep filling
// until every stage is full; only then is hsv_stall raised.
// Reset clears all valid bits, so the pipeline comes up empty with rgb_valid low.
module hsv_to_rgb_converter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              hsv_valid,
    output logic              hsv_stall,
    input  hsvrgb_pkg::hsv_t  hsv,
    output logic              rgb_valid,
    input  logic              rgb_stall,
    output hsvrgb_pkg::rgb_t  rgb
);

    logic              split_ready;
    logic              frac_valid;
    logic              weight_ready;
    hsvrgb_pkg::frac_t frac_word;
    logic              chan_valid;
    logic              mix_ready;
    hsvrgb_pkg::chan_t chan_word;

    assign hsv_stall = !split_ready;

    hsvrgb_split u_split (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (hsv_valid),
        .up_ready (split_ready),
        .up_word  (hsv),
        .dn_valid (frac_valid),
        .dn_ready (weight_ready),
        .dn_word  (frac_word)
    );

    hsvrgb_weight u_weight (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (frac_valid),
        .up_ready (weight_ready),
        .up_word  (frac_word),
        .dn_valid (chan_valid),
        .dn_ready (mix_ready),
        .dn_word  (chan_word)
    );

    hsvrgb_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (chan_valid),
        .up_ready  (mix_ready),
        .up_word   (chan_word),
        .out_valid (rgb_valid),
        .out_stall (rgb_stall),
        .out_word  (rgb)
    );

    // Input back-pressure only appears when a result is held at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        hsv_stall |-> (rgb_valid && rgb_stall))
        else $error("input stalled while the output is not held");

    // A word taken while rgb_stall stays low reaches the output with rgb_valid set.
    assert property (@(posedge clk) disable iff (!rst_n)
        (hsv_valid && !hsv_stall) ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall
        ##1 !rgb_stall |=> rgb_valid)
        else $error("accepted word did not reach the output in five cycles");

    // An invalid result always carries the all-ones color.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rgb_valid && rgb.invalid) |-> (rgb.rgb_word == '1))
        else $error("invalid result without all-ones color");

endmodule
